/* rtl/core/rgnt_pkg.sv */
// Shared types, widths and controller states for the running gcd nullity tracker.
package rgnt_pkg;

	localparam int DIM_WIDTH   = 16;
	localparam int ID_WIDTH    = 16;
	localparam int LIMIT_WIDTH = 16;
	localparam int SHIFT_WIDTH = $clog2(DIM_WIDTH);
	localparam int CMP_WIDTH   = (DIM_WIDTH > LIMIT_WIDTH) ? DIM_WIDTH : LIMIT_WIDTH;

	typedef logic [DIM_WIDTH-1:0]   dim_t;
	typedef logic [ID_WIDTH-1:0]    id_t;
	typedef logic [LIMIT_WIDTH-1:0] limit_t;
	typedef logic [SHIFT_WIDTH-1:0] shift_t;

	typedef struct packed {
		dim_t rank_value;
		dim_t row_count;
		id_t  element_id;
	} in_word_t;

	typedef struct packed {
		logic stop_search;
		dim_t current_divisor;
		logic best_valid;
		id_t  best_element;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_GCD,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic start_gcd;
		logic gcd_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_gcd;
		logic gcd_done;
		logic out_free;
	} ctrl_status_t;

endpackage

/* rtl/core/rgnt_gcd.sv */
// Iterative binary gcd unit: one halving or subtract-and-halve step per cycle while step is high.
module rgnt_gcd (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          step,
	input  rgnt_pkg::dim_t a_in,
	input  rgnt_pkg::dim_t b_in,
	output logic          done,
	output rgnt_pkg::dim_t result
);
	import rgnt_pkg::*;

	dim_t   a_q;
	dim_t   b_q;
	shift_t k_q;
	dim_t   a_minus_b;
	dim_t   b_minus_a;

	assign a_minus_b = a_q - b_q;
	assign b_minus_a = b_q - a_q;
	assign done      = (a_q == b_q);
	assign result    = a_q << k_q;

	// Operands are nonzero, so the pair always meets at a common value, which is
	// scaled back by the shared factors of two counted in k_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (start) begin
			k_q <= '0;
		end else if (step && !a_q[0] && !b_q[0]) begin
			k_q <= k_q + shift_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
		end else if (step) begin
			case ({a_q[0], b_q[0]})
				2'b00: begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end
				2'b01: a_q <= a_q >> 1;
				2'b10: b_q <= b_q >> 1;
				default: begin
					if (a_q >= b_q) begin
						a_q <= a_minus_b >> 1;
					end else begin
						b_q <= b_minus_a >> 1;
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_gcd_nonzero_operands: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (a_q != '0 && b_q != '0))
		else $error("gcd unit loaded with a zero operand");

	a_gcd_no_step_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !done)
		else $error("gcd unit stepped after convergence");
`endif

endmodule

/* rtl/core/rgnt_datapath.sv */
// Datapath: limit register, item latch, tracker state, gcd unit and output register.
module rgnt_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  rgnt_pkg::limit_t      cfg_data,
	input  rgnt_pkg::in_word_t    in_word,
	input  logic                  out_stall,
	output logic                  out_valid,
	output rgnt_pkg::out_word_t   out_word,
	input  rgnt_pkg::ctrl_cmd_t   cmd,
	output rgnt_pkg::ctrl_status_t status
);
	import rgnt_pkg::*;

	limit_t    limit_q;
	dim_t      rank_q;
	dim_t      rows_q;
	id_t       id_q;
	dim_t      divisor_q;
	logic      best_present_q;
	id_t       best_id_q;
	logic      out_valid_q;
	out_word_t out_word_q;

	dim_t shortfall;
	logic candidate;
	logic gcd_done;
	dim_t gcd_value;

	dim_t nxt_divisor;
	logic nxt_present;
	id_t  nxt_id;
	logic nxt_stop;

	assign shortfall = rows_q - rank_q;
	assign candidate = (limit_q != '0) && (rank_q < rows_q)
		&& (CMP_WIDTH'(shortfall) <= CMP_WIDTH'(limit_q));

	rgnt_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_gcd),
		.step   (cmd.gcd_step),
		.a_in   (divisor_q),
		.b_in   (shortfall),
		.done   (gcd_done),
		.result (gcd_value)
	);

	always_comb begin
		nxt_divisor = divisor_q;
		nxt_present = best_present_q;
		nxt_id      = best_id_q;
		nxt_stop    = 1'b0;
		if (limit_q == '0) begin
			if (rank_q == rows_q) begin
				nxt_divisor = dim_t'(1);
				nxt_present = 1'b1;
				nxt_id      = id_q;
				nxt_stop    = 1'b1;
			end
		end else if (candidate) begin
			if (divisor_q == '0) begin
				nxt_divisor = shortfall;
				nxt_present = 1'b1;
				nxt_id      = id_q;
			end else if (gcd_value < divisor_q) begin
				// The divisor shrinks: the old best no longer achieves it.
				nxt_divisor = gcd_value;
				if (shortfall == gcd_value) begin
					nxt_present = 1'b1;
					nxt_id      = id_q;
				end else begin
					nxt_present = 1'b0;
					nxt_id      = '0;
				end
			end else if (!best_present_q && shortfall == divisor_q) begin
				nxt_present = 1'b1;
				nxt_id      = id_q;
			end
			nxt_stop = (nxt_divisor == dim_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= '0;
			divisor_q      <= '0;
			best_present_q <= 1'b0;
			best_id_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.commit) begin
				divisor_q      <= nxt_divisor;
				best_present_q <= nxt_present;
				best_id_q      <= nxt_id;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			rank_q <= in_word.rank_value;
			rows_q <= in_word.row_count;
			id_q   <= in_word.element_id;
		end
		if (cmd.commit) begin
			out_word_q.stop_search     <= nxt_stop;
			out_word_q.current_divisor <= nxt_divisor;
			out_word_q.best_valid      <= nxt_present;
			out_word_q.best_element    <= nxt_present ? nxt_id : '0;
		end
	end

	assign status.needs_gcd = candidate && (divisor_q != '0);
	assign status.gcd_done  = gcd_done;
	assign status.out_free  = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;
	assign out_word         = out_word_q;

`ifndef SYNTHESIS
	a_dp_commit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status.out_free)
		else $error("result committed while the output word was still held");

	a_dp_divisor_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(divisor_q != '0) |=> (divisor_q != '0 && divisor_q <= $past(divisor_q)))
		else $error("running divisor grew or returned to zero");
`endif

endmodule

/* rtl/core/rgnt_ctrl.sv */
// Controller state machine: sequences latch, gcd iteration when needed and commit of one word.
module rgnt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rgnt_pkg::ctrl_status_t status,
	output rgnt_pkg::ctrl_cmd_t    cmd
);
	import rgnt_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.needs_gcd) begin
					cmd.start_gcd = 1'b1;
					state_nxt     = ST_GCD;
				end else begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_GCD: begin
				if (status.gcd_done) begin
					state_nxt = ST_COMMIT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_COMMIT: begin
				// Hold here until the output register can take the result.
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/running_gcd_nullity_tracker.sv */
// Top level of the running gcd nullity tracker: controller plus datapath.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+----------------------------
//  config   | cfg_we              | cfg_data (nullity limit)
//  input    | in_valid / in_stall | in_word  (rank, rows, id)
//  output   | out_valid/out_stall | out_word (stop, divisor, best)
//
// An item is latched in the idle state, then evaluated, then taken through
// gcd iteration when a gcd is needed, one binary gcd step per cycle, and
// then committed. Reset clears the limit, divisor and best record.
// A stalled output word holds, and the next item is accepted meanwhile; its
// result waits in the commit state until the output register frees up.
module running_gcd_nullity_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  rgnt_pkg::limit_t    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  rgnt_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output rgnt_pkg::out_word_t out_word
);
	import rgnt_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	rgnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rgnt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
